FILE: design/region_masked_polynomial_eval_assert.svh
// Assertion macros for the region masked polynomial evaluator.
`ifndef REGION_MASKED_POLYNOMIAL_EVAL_ASSERT_SVH
`define REGION_MASKED_POLYNOMIAL_EVAL_ASSERT_SVH
`ifndef SYNTH
`define RMPE_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define RMPE_ASSERT_RST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RMPE_ASSERT(label, clk, rst_n, prop, msg)
`define RMPE_ASSERT_RST(label, clk, prop, msg)
`endif
`endif

FILE: design/rmpe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rmpe_pkg;
  localparam int unsigned EdgeW  = 32;
  localparam int unsigned ValW   = 48;
  localparam int unsigned CntW   = 6;
  localparam int unsigned CfgIdxW = 3;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_FULL    = 2'd1,
    ST_OUTSIDE = 2'd2
  } status_t;

  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_EVAL = 1'b1;

  localparam logic [CfgIdxW-1:0] REG_NUM_COEFFS = 3'd0;

  localparam logic signed [ValW-1:0] POS48 = {1'b0, {(ValW-1){1'b1}}};
  localparam logic signed [ValW-1:0] NEG48 = {1'b1, {(ValW-1){1'b0}}};

  // Control from sequencer to multiplier.
  typedef struct packed {
    logic start;
  } mul_ctl_t;
endpackage
`default_nettype wire

FILE: design/rmpe_mac.sv
`timescale 1ns / 1ps
`default_nettype none
// Horner step: floor(acc*x/2^16)+c, saturated to 48 bits. The multiply is
// split into two 24x32 partial products, registered one after the other.
module rmpe_mac (
  input  wire                         clk,
  input  wire                         rst_n,
  input  rmpe_pkg::mul_ctl_t          ctl,
  input  wire  signed [47:0]          acc,
  input  wire  signed [31:0]          x,
  input  wire  signed [31:0]          coeff,
  output logic                        done,
  output logic signed [47:0]          result
);
  import rmpe_pkg::*;

  logic [1:0]          phase_r;
  logic signed [56:0]  plo_r;   // acc[23:0] (unsigned) * x
  logic signed [56:0]  phi_r;   // acc[47:24] (signed) * x
  logic signed [31:0]  c_r;
  logic signed [81:0]  prod;
  logic signed [65:0]  shifted;
  logic signed [66:0]  sum;

  // Form the low partial product, then the high one.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 2'd0;
    end else begin
      if (ctl.start) begin
        phase_r <= 2'd1;
      end else if (phase_r == 2'd1) begin
        phase_r <= 2'd2;
      end else begin
        phase_r <= 2'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      plo_r <= 57'(signed'({1'b0, acc[23:0]}) * x);
      c_r   <= coeff;
    end
    if (phase_r == 2'd1) begin
      phi_r <= 57'(signed'(acc[47:24]) * x);
    end
  end

  // Combine, shift down by 16, add coefficient, saturate.
  always_comb begin
    prod    = (82'(phi_r) <<< 24) + 82'(plo_r);
    shifted = 66'(prod >>> 16);
    sum     = 67'(shifted) + 67'(c_r);
    if (sum > 67'(POS48)) begin
      result = POS48;
    end else if (sum < 67'(NEG48)) begin
      result = NEG48;
    end else begin
      result = sum[47:0];
    end
    done = (phase_r == 2'd2);
  end
endmodule
`default_nettype wire

FILE: design/region_masked_polynomial_eval.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel | Direction | Payload
// in_     | slave     | tdata {second_edge, first_edge}, tuser command
// out_    | master    | tdata {boundary_count, value, inside_res, status}
// cfg_    | write     | index 0 num_coeffs, 1..6 coeff_0..coeff_5
// An evaluate scans stored boundaries, reading and then comparing each entry,
// then runs up to MAX_COEFFS-1 Horner steps in a shared MAC.
// An add scans the same way for each edge and then moves the tail of the store,
// reading and then writing each entry.
// The store needs no clearing after reset; count resets to zero.
// The result register holds while out_tready is low; a new beat may be taken
// meanwhile, and its result waits in S_OUT until the register is free.
module region_masked_polynomial_eval #(
  parameter int unsigned MAX_BOUNDS = 32,
  parameter int unsigned MAX_COEFFS = 6
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [63:0] in_tdata,   // first_edge[31:0], second_edge[63:32]
  input  wire         in_tuser,   // command
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [63:0] out_tdata,  // status[1:0], inside_res[2], value[50:3],
                                  // boundary_count[56:51], zero[63:57]
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [2:0]  cfg_index,
  input  wire  [31:0] cfg_data
);
  import rmpe_pkg::*;
`include "region_masked_polynomial_eval_assert.svh"

  localparam int unsigned AW = (MAX_BOUNDS > 1) ? $clog2(MAX_BOUNDS) : 1;
  localparam int unsigned PW = $clog2(MAX_BOUNDS + 3);

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN_LO, S_SCAN_HI, S_DECIDE, S_SHIFT, S_WRLO, S_WRHI,
    S_HSTART, S_HWAIT, S_OUT
  } state_t;

  // Register file.
  logic [2:0]         num_coeffs_r;
  logic signed [31:0] coeff_r [MAX_COEFFS];

  // Boundary memory with one write and one registered read.
  logic signed [31:0] mem [MAX_BOUNDS];
  logic [AW-1:0]      rd_addr;
  logic signed [31:0] rd_data_r;
  logic               we;
  logic [AW-1:0]      wr_addr;
  logic signed [31:0] wr_data;

  state_t             state_r;
  logic [PW-1:0]      count_r;
  logic [PW-1:0]      ptr_r;     // scan position
  logic               rd_ok_r;   // rd_data_r holds entry at ptr_r
  logic [PW-1:0]      i_r, j_r;
  logic [PW-1:0]      src_r, dst_r;
  logic               cmd_r;
  logic signed [31:0] lo_r, hi_r;
  logic signed [47:0] acc_r;
  logic [2:0]         step_r;
  logic [1:0]         status_r;
  logic               inside_r;
  logic [63:0]        out_data_r;
  logic               out_valid_r;

  logic signed [31:0] e1, e2;
  logic [2:0]         n_eff;
  logic [PW:0]        newc;
  logic               add_lo, add_hi;
  logic signed [31:0] key;
  logic               stop_scan;
  mul_ctl_t           mctl;
  logic               mdone;
  logic signed [47:0] mres;
  logic signed [31:0] mcoeff;

  assign e1 = signed'(in_tdata[31:0]);
  assign e2 = signed'(in_tdata[63:32]);
  assign in_tready = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    if (num_coeffs_r == 3'd0) begin
      n_eff = 3'd1;
    end else if (32'(num_coeffs_r) > MAX_COEFFS) begin
      n_eff = 3'(MAX_COEFFS);
    end else begin
      n_eff = num_coeffs_r;
    end
  end

  assign key       = (state_r == S_SCAN_HI) ? hi_r : lo_r;
  assign stop_scan = (ptr_r >= count_r) || (rd_ok_r && !(rd_data_r < key));
  assign add_lo    = !i_r[0];
  assign add_hi    = !j_r[0];
  assign newc      = (PW+1)'(i_r) + (PW+1)'(add_lo) + (PW+1)'(add_hi)
                   + (PW+1)'(count_r) - (PW+1)'(j_r);
  // step_r has not yet moved down when the MAC takes the coefficient, so index below it
  assign mcoeff    = coeff_r[3'(step_r - 3'd1)];
  assign mctl.start = (state_r == S_HSTART);

  rmpe_mac u_mac (
    .clk(clk), .rst_n(rst_n), .ctl(mctl), .acc(acc_r), .x(lo_r),
    .coeff(mcoeff), .done(mdone), .result(mres)
  );

  // Read address: scan follows ptr, shift reads the source entry.
  always_comb begin
    rd_addr = AW'(ptr_r);
    if (state_r == S_SHIFT) begin
      rd_addr = AW'(src_r);
    end
  end

  // Write control for the store.
  always_comb begin
    we      = 1'b0;
    wr_addr = AW'(dst_r);
    wr_data = rd_data_r;
    case (state_r)
      S_SHIFT: we = rd_ok_r;
      S_WRLO:  begin
        we = add_lo; wr_addr = AW'(i_r); wr_data = lo_r;
      end
      S_WRHI:  begin
        we = add_hi; wr_addr = AW'(i_r + PW'(add_lo)); wr_data = hi_r;
      end
      default: we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_coeffs_r <= 3'd1;
      for (int k = 0; k < MAX_COEFFS; k++) coeff_r[k] <= '0;
    end else if (cfg_valid) begin
      if (cfg_index == REG_NUM_COEFFS) begin
        num_coeffs_r <= cfg_data[2:0];
      end else if (32'(cfg_index) <= MAX_COEFFS) begin
        coeff_r[3'(cfg_index - 3'd1)] <= signed'(cfg_data);
      end
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      rd_ok_r     <= 1'b0;
    end else begin
      if (out_valid_r && out_tready) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_tvalid && in_tready) begin
            cmd_r    <= in_tuser;
            status_r <= ST_DONE;
            inside_r <= 1'b0;
            acc_r    <= '0;
            if (in_tuser == CMD_ADD) begin
              lo_r <= (e1 < e2) ? e1 : e2;
              hi_r <= (e1 < e2) ? e2 : e1;
            end else begin
              lo_r <= e1;
            end
            ptr_r   <= '0;
            rd_ok_r <= 1'b0;
            state_r <= S_SCAN_LO;
          end
        end
        S_SCAN_LO, S_SCAN_HI: begin
          // Alternate read issue and compare for each entry to keep the address and
          // data aligned.
          if (stop_scan) begin
            rd_ok_r <= 1'b0;
            if (state_r == S_SCAN_LO) begin
              i_r <= ptr_r;
              if (cmd_r == CMD_EVAL) begin
                if (!ptr_r[0]) begin
                  status_r <= ST_OUTSIDE;
                  state_r  <= S_OUT;
                end else begin
                  inside_r <= 1'b1;
                  acc_r    <= 48'(coeff_r[3'(n_eff - 3'd1)]);
                  step_r   <= n_eff - 3'd1;
                  state_r  <= (n_eff == 3'd1) ? S_OUT : S_HSTART;
                end
              end else begin
                state_r <= S_SCAN_HI;
              end
            end else begin
              j_r     <= ptr_r;
              state_r <= S_DECIDE;
            end
          end else if (rd_ok_r) begin
            ptr_r   <= ptr_r + PW'(1);
            rd_ok_r <= 1'b0;
          end else begin
            rd_ok_r <= 1'b1;
          end
        end
        S_DECIDE: begin
          if (newc > (PW+1)'(MAX_BOUNDS)) begin
            status_r <= ST_FULL;
            state_r  <= S_OUT;
          end else begin
            // Move the tail; direction depends on growth or shrink.
            if (i_r + PW'(add_lo) + PW'(add_hi) > j_r) begin
              src_r <= count_r - PW'(1);
              dst_r <= PW'(newc) - PW'(1);
            end else begin
              dst_r <= i_r + PW'(add_lo) + PW'(add_hi);
              src_r <= j_r;
            end
            rd_ok_r <= 1'b0;
            state_r <= S_SHIFT;
          end
        end
        S_SHIFT: begin
          // Read then write each tail entry in turn.
          if (j_r >= count_r || i_r + PW'(add_lo) + PW'(add_hi) == j_r) begin
            state_r <= S_WRLO;
          end else if (!rd_ok_r) begin
            rd_ok_r <= 1'b1;
          end else begin
            rd_ok_r <= 1'b0;
            if (i_r + PW'(add_lo) + PW'(add_hi) > j_r) begin
              if (src_r == j_r) state_r <= S_WRLO;
              src_r <= src_r - PW'(1);
              dst_r <= dst_r - PW'(1);
            end else begin
              if (src_r == count_r - PW'(1)) state_r <= S_WRLO;
              src_r <= src_r + PW'(1);
              dst_r <= dst_r + PW'(1);
            end
          end
        end
        S_WRLO: begin
          rd_ok_r <= 1'b0;
          state_r <= S_WRHI;
        end
        S_WRHI: begin
          count_r <= PW'(newc);
          state_r <= S_OUT;
        end
        S_HSTART: begin
          step_r  <= step_r - 3'd1;
          state_r <= S_HWAIT;
        end
        S_HWAIT: begin
          if (mdone) begin
            acc_r   <= mres;
            state_r <= (step_r == 3'd0) ? S_OUT : S_HSTART;
          end
        end
        S_OUT: begin
          if (!out_valid_r) begin
            out_valid_r <= 1'b1;
            out_data_r  <= {7'd0, 6'(count_r), acc_r, inside_r, status_r};
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `RMPE_ASSERT(a_no_accept_busy, clk, rst_n, (in_tvalid && in_tready) |-> (state_r == S_IDLE), "beat taken while busy")
  `RMPE_ASSERT(a_count_range, clk, rst_n, 1'b1 |-> (32'(count_r) <= MAX_BOUNDS), "count over store size")
  `RMPE_ASSERT(a_out_hold, clk, rst_n, (out_valid_r && !out_tready) |=> $stable(out_data_r), "result changed while stalled")
endmodule
`default_nettype wire
